// ===== rtl/tlik_pkg.sv =====
// Package for the two-link arm solver: widths, register indexes, sideband struct
// and the CORDIC arctangent table. No dependencies.
package tlik_pkg;

  localparam int COORD_BITS = 10;
  localparam int ANGLE_BITS = 16;
  localparam int LEN_BITS   = 9;
  localparam int CFG_W      = (COORD_BITS > LEN_BITS) ? COORD_BITS : LEN_BITS;

  localparam int CW        = COORD_BITS + 1;          // signed offset from pivot
  localparam int D2_W      = 2 * COORD_BITS + 1;      // dx^2 + dy^2
  localparam int SQ_ROOT_W = (D2_W + 16 + 1) / 2;     // root of d2 in Q.8
  localparam int SQ_IN_W   = 2 * SQ_ROOT_W;
  localparam int SUM_W     = LEN_BITS + 1;
  localparam int C8_W      = SUM_W + 8;               // clamped distance, Q.8
  localparam int NUM_W     = 2 * C8_W + 2;            // signed numerators
  localparam int MAG_W     = NUM_W - 1;
  localparam int DEN_W     = LEN_BITS + C8_W + 9;     // 2*a*c8 << 8
  localparam int Q_W       = 17;                      // cosine magnitude, Q16 up to 1.0
  localparam int CQ_W      = Q_W + 1;
  localparam int XW        = 35;                      // CORDIC datapath
  localparam int CORDIC_STEPS = 28;

  localparam int SQ_LAT  = SQ_ROOT_W;
  localparam int DIV_LAT = Q_W;
  localparam int COR_LAT = CORDIC_STEPS + 1;

  localparam logic [Q_W-1:0] CQ_ONE       = Q_W'(65536);
  localparam logic [31:0]    QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0]    HALF_TURN    = 32'h8000_0000;

  typedef enum logic [1:0] {
    CFG_BASE_X        = 2'd0,
    CFG_BASE_Y        = 2'd1,
    CFG_FIRST_LENGTH  = 2'd2,
    CFG_SECOND_LENGTH = 2'd3
  } cfg_idx_e;

  // Sideband that travels alongside the arithmetic units
  typedef struct packed {
    logic                  valid;
    logic                  zero;
    logic                  reach;
    logic                  sat;
    logic                  neg1;
    logic                  neg2;
    logic signed [CW-1:0]  dx;
    logic signed [CW-1:0]  dy;
    logic [LEN_BITS-1:0]   a;
    logic [LEN_BITS-1:0]   b;
    logic [SUM_W-1:0]      sum;
    logic signed [CQ_W-1:0] cq1;
    logic signed [CQ_W-1:0] cq2;
  } sb_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_tab(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
      27: v = 32'h00000005;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/tlik_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on tlik_pkg.
module tlik_sqrt import tlik_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [SQ_IN_W-1:0]   rad_i,
  output logic [SQ_ROOT_W-1:0] root_o
);

  localparam int RW = SQ_ROOT_W + 2;
  localparam int TW = SQ_ROOT_W + 4;

  logic [SQ_IN_W-1:0]   rad_q  [SQ_ROOT_W];
  logic [SQ_IN_W-1:0]   rad_d  [SQ_ROOT_W];
  logic [SQ_IN_W-1:0]   rad_p  [SQ_ROOT_W];
  logic [RW-1:0]        rem_q  [SQ_ROOT_W];
  logic [RW-1:0]        rem_d  [SQ_ROOT_W];
  logic [RW-1:0]        rem_p  [SQ_ROOT_W];
  logic [SQ_ROOT_W-1:0] root_q [SQ_ROOT_W];
  logic [SQ_ROOT_W-1:0] root_d [SQ_ROOT_W];
  logic [SQ_ROOT_W-1:0] root_p [SQ_ROOT_W];
  logic [TW-1:0]        trial  [SQ_ROOT_W];
  logic [TW-1:0]        cand   [SQ_ROOT_W];
  logic [TW-1:0]        diff   [SQ_ROOT_W];

  always_comb begin
    rad_p[0]  = rad_i;
    rem_p[0]  = '0;
    root_p[0] = '0;
    for (int k = 1; k < SQ_ROOT_W; k++) begin
      rad_p[k]  = rad_q[k-1];
      rem_p[k]  = rem_q[k-1];
      root_p[k] = root_q[k-1];
    end
    for (int k = 0; k < SQ_ROOT_W; k++) begin
      trial[k] = {rem_p[k], rad_p[k][SQ_IN_W-1 -: 2]};
      cand[k]  = TW'({root_p[k], 2'b01});
      diff[k]  = trial[k] - cand[k];
      rad_d[k] = rad_p[k] << 2;
      if (trial[k] >= cand[k]) begin
        rem_d[k]  = diff[k][RW-1:0];
        root_d[k] = {root_p[k][SQ_ROOT_W-2:0], 1'b1};
      end else begin
        rem_d[k]  = trial[k][RW-1:0];
        root_d[k] = {root_p[k][SQ_ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SQ_ROOT_W; k++) begin
        rad_q[k]  <= rad_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
    end
  end

  assign root_o = root_q[SQ_ROOT_W-1];

endmodule

// ===== rtl/tlik_div.sv =====
// Pipelined restoring divider for the cosine quotient: floor(mag * 2^16 / den),
// one quotient bit per stage, with an overflow flag. Depends on tlik_pkg.
module tlik_div import tlik_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [MAG_W-1:0] mag_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   q_o,
  output logic             ovf_o
);

  logic [DEN_W-1:0] r_q   [Q_W];
  logic [DEN_W-1:0] r_d   [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   q_q   [Q_W];
  logic [Q_W-1:0]   q_d   [Q_W];
  logic             ovf_q [Q_W];
  logic [DEN_W:0]   t     [Q_W];
  logic [MAG_W-1:0] m0;
  logic             q0;

  always_comb begin
    // top quotient bit straight from the magnitude; >= 2*den always saturates
    q0     = (MAG_W + 1)'(mag_i) >= (MAG_W + 1)'(den_i);
    m0     = mag_i - MAG_W'(den_i);
    r_d[0] = q0 ? m0[DEN_W-1:0] : mag_i[DEN_W-1:0];
    q_d[0] = Q_W'(q0);
    t[0]   = '0;
    for (int k = 1; k < Q_W; k++) begin
      t[k] = {r_q[k-1], 1'b0};
      if (t[k] >= {1'b0, den_q[k-1]}) begin
        r_d[k] = DEN_W'(t[k] - {1'b0, den_q[k-1]});
        q_d[k] = {q_q[k-1][Q_W-2:0], 1'b1};
      end else begin
        r_d[k] = t[k][DEN_W-1:0];
        q_d[k] = {q_q[k-1][Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= den_i;
      ovf_q[0] <= (MAG_W + 1)'(mag_i) >= (MAG_W + 1)'({den_i, 1'b0});
      for (int k = 0; k < Q_W; k++) begin
        r_q[k] <= r_d[k];
        q_q[k] <= q_d[k];
      end
      for (int k = 1; k < Q_W; k++) begin
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign q_o   = q_q[Q_W-1];
  assign ovf_o = ovf_q[Q_W-1];

endmodule

// ===== rtl/tlik_cordic.sv =====
// Pipelined CORDIC vectoring unit: atan2(y, x) in units of 2^-32 turn.
// Quadrant pre-rotation stage, then one micro-rotation per stage. Depends on tlik_pkg.
module tlik_cordic import tlik_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  output logic [31:0]          z_o
);

  logic signed [XW-1:0] x_q [COR_LAT];
  logic signed [XW-1:0] x_d [COR_LAT];
  logic signed [XW-1:0] y_q [COR_LAT];
  logic signed [XW-1:0] y_d [COR_LAT];
  logic [31:0]          z_q [COR_LAT];
  logic [31:0]          z_d [COR_LAT];
  logic signed [XW-1:0] xs  [COR_LAT];
  logic signed [XW-1:0] ys  [COR_LAT];

  always_comb begin
    x_d[0] = x_i;
    y_d[0] = y_i;
    z_d[0] = '0;
    xs[0]  = '0;
    ys[0]  = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x_d[0] = y_i;
        y_d[0] = -x_i;
        z_d[0] = QUARTER_TURN;
      end else begin
        x_d[0] = -y_i;
        y_d[0] = x_i;
        z_d[0] = 32'h0 - QUARTER_TURN;
      end
    end
    for (int k = 1; k < COR_LAT; k++) begin
      xs[k] = x_q[k-1] >>> (k - 1);
      ys[k] = y_q[k-1] >>> (k - 1);
      // y = 0 counts as positive
      if (y_q[k-1] >= 0) begin
        x_d[k] = x_q[k-1] + ys[k];
        y_d[k] = y_q[k-1] - xs[k];
        z_d[k] = z_q[k-1] + atan_tab(k - 1);
      end else begin
        x_d[k] = x_q[k-1] - ys[k];
        y_d[k] = y_q[k-1] + xs[k];
        z_d[k] = z_q[k-1] - atan_tab(k - 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < COR_LAT; k++) begin
        x_q[k] <= x_d[k];
        y_q[k] <= y_d[k];
        z_q[k] <= z_d[k];
      end
    end
  end

  assign z_o = z_q[COR_LAT-1];

endmodule

// ===== rtl/two_link_inverse_kinematics.sv =====
// Two-link planar arm solver, top level: config registers, pipeline sideband,
// glue stages. Depends on tlik_pkg, tlik_sqrt, tlik_div, tlik_cordic.
//
// Takes one target point per cycle and returns the base and outer segment angles
// as binary angles (full turn = 2^ANGLE_BITS). The whole datapath is one stalling
// pipeline; at the default widths a beat passes two 19-stage square roots, a
// 17-stage divider, a 29-stage CORDIC and glue stages, and the sustained rate is
// one beat per cycle while the output is not stalled. in_ready_o drops only while a
// result sits on the output and out_ready_i is low. Configuration is sampled
// as beats enter, so write it while the pipeline is empty.
module two_link_inverse_kinematics import tlik_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] target_x_i,
  input  logic [COORD_BITS-1:0] target_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ANGLE_BITS-1:0] base_angle_o,
  output logic [ANGLE_BITS-1:0] outer_angle_o,
  output logic                  out_of_reach_o,
  output logic                  degenerate_o
);

  // positions of the stages along the sideband line
  localparam int P1   = 1;
  localparam int P3A  = P1 + SQ_LAT + 1;
  localparam int P3B  = P3A + 1;
  localparam int P5   = P3B + DIV_LAT + 1;
  localparam int P6   = P5 + SQ_LAT;
  localparam int PZ   = P6 + COR_LAT;
  localparam int POUT = PZ + 1;
  localparam int TOT  = POUT + 1;

  function automatic logic [ANGLE_BITS-1:0] to_angle(input logic [31:0] z);
    logic [31:0] t;
    t = z + (32'd1 << (31 - ANGLE_BITS));
    return t[31 -: ANGLE_BITS];
  endfunction

  logic [COORD_BITS-1:0] base_x_q, base_y_q;
  logic [LEN_BITS-1:0]   first_len_q, second_len_q;

  logic en;
  sb_t  sb_q [TOT];
  sb_t  sb_d [TOT];

  logic signed [2*CW-1:0] dxx, dyy;
  logic [D2_W-1:0]        d2, d2_q;
  logic [2*SUM_W-1:0]     sum2;
  logic [SQ_ROOT_W-1:0]   root1, rt1, rt2;
  logic [C8_W-1:0]        c8;
  logic [2*LEN_BITS-1:0]  aa_q, bb_q, ab_q;
  logic [2*C8_W-1:0]      cc_q;
  logic [LEN_BITS+C8_W-1:0] ac_q;
  logic [NUM_W-1:0]       n1, n2, n1_abs, n2_abs;
  logic [MAG_W-1:0]       mag1_q, mag2_q;
  logic [DEN_W-1:0]       den1_q, den2_q;
  logic [Q_W-1:0]         q1, q2, cm1, cm2;
  logic                   ovf1, ovf2, sat1, sat2;
  logic [2*Q_W-1:0]       cm1_sq, cm2_sq;
  logic [32:0]            rr1_q, rr2_q;
  logic signed [XW-1:0]   xb, yb, xc, yc, xd, yd;
  logic [31:0]            bz, cz, dz, base_z, outer_z;
  logic [ANGLE_BITS-1:0]  base_q, outer_q;
  logic                   reach_q, degen_q;
  logic [LEN_BITS-1:0]    a0, b0;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q     <= COORD_BITS'(200);
      base_y_q     <= COORD_BITS'(200);
      first_len_q  <= LEN_BITS'(100);
      second_len_q <= LEN_BITS'(100);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BASE_X:        base_x_q     <= cfg_data_i[COORD_BITS-1:0];
        CFG_BASE_Y:        base_y_q     <= cfg_data_i[COORD_BITS-1:0];
        CFG_FIRST_LENGTH:  first_len_q  <= cfg_data_i[LEN_BITS-1:0];
        CFG_SECOND_LENGTH: second_len_q <= cfg_data_i[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign en         = !sb_q[POUT].valid || out_ready_i;
  assign in_ready_o = en;

  assign a0 = (first_len_q == '0) ? LEN_BITS'(1) : first_len_q;
  assign b0 = (second_len_q == '0) ? LEN_BITS'(1) : second_len_q;

  // squared distance and reach test
  assign dxx  = sb_q[0].dx * sb_q[0].dx;
  assign dyy  = sb_q[0].dy * sb_q[0].dy;
  assign d2   = dxx[D2_W-1:0] + dyy[D2_W-1:0];
  assign sum2 = sb_q[0].sum * sb_q[0].sum;

  // after the divider: saturate the cosines
  assign sat1 = ovf1 || (q1 > CQ_ONE);
  assign sat2 = ovf2 || (q2 > CQ_ONE);
  assign cm1  = sat1 ? CQ_ONE : q1;
  assign cm2  = sat2 ? CQ_ONE : q2;

  always_comb begin
    sb_d[0]       = '0;
    sb_d[0].valid = in_valid_i;
    sb_d[0].dx    = CW'({1'b0, target_x_i}) - CW'({1'b0, base_x_q});
    sb_d[0].dy    = CW'({1'b0, target_y_i}) - CW'({1'b0, base_y_q});
    sb_d[0].a     = a0;
    sb_d[0].b     = b0;
    sb_d[0].sum   = SUM_W'(a0) + SUM_W'(b0);
    for (int k = 1; k < TOT; k++) sb_d[k] = sb_q[k-1];
    sb_d[P1].zero  = (d2 == '0);
    sb_d[P1].reach = 48'(d2) > 48'(sum2);
    sb_d[P3B].neg1 = n1[NUM_W-1];
    sb_d[P3B].neg2 = n2[NUM_W-1];
    sb_d[P5].sat   = sat1 || sat2;
    sb_d[P5].cq1   = sb_q[P5-1].neg1 ? -CQ_W'(cm1) : CQ_W'(cm1);
    sb_d[P5].cq2   = sb_q[P5-1].neg2 ? -CQ_W'(cm2) : CQ_W'(cm2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TOT; k++) sb_q[k] <= '0;
    end else if (en) begin
      for (int k = 0; k < TOT; k++) sb_q[k] <= sb_d[k];
    end
  end

  // clamp c, then the products
  assign c8 = sb_q[P3A-1].reach ? {sb_q[P3A-1].sum, 8'b0} : root1[C8_W-1:0];

  // numerators and denominators of both cosines
  assign n1 = NUM_W'({aa_q, 16'b0}) + NUM_W'(cc_q) - NUM_W'({bb_q, 16'b0});
  assign n2 = NUM_W'({(2*LEN_BITS+1)'(aa_q) + (2*LEN_BITS+1)'(bb_q), 16'b0})
            - NUM_W'(cc_q);
  assign n1_abs = n1[NUM_W-1] ? -n1 : n1;
  assign n2_abs = n2[NUM_W-1] ? -n2 : n2;

  assign cm1_sq = cm1 * cm1;
  assign cm2_sq = cm2 * cm2;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q   <= d2;
      aa_q   <= sb_q[P3A-1].a * sb_q[P3A-1].a;
      bb_q   <= sb_q[P3A-1].b * sb_q[P3A-1].b;
      ab_q   <= sb_q[P3A-1].a * sb_q[P3A-1].b;
      cc_q   <= c8 * c8;
      ac_q   <= sb_q[P3A-1].a * c8;
      mag1_q <= n1_abs[MAG_W-1:0];
      mag2_q <= n2_abs[MAG_W-1:0];
      den1_q <= {ac_q, 9'b0};
      den2_q <= DEN_W'({ab_q, 17'b0});
      rr1_q  <= 33'h1_0000_0000 - 33'(cm1_sq);
      rr2_q  <= 33'h1_0000_0000 - 33'(cm2_sq);
    end
  end

  tlik_sqrt u_sqrt_c (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (SQ_IN_W'({d2_q, 16'b0})),
    .root_o (root1)
  );

  tlik_div u_div_b (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (mag1_q),
    .den_i (den1_q),
    .q_o   (q1),
    .ovf_o (ovf1)
  );

  tlik_div u_div_c (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (mag2_q),
    .den_i (den2_q),
    .q_o   (q2),
    .ovf_o (ovf2)
  );

  tlik_sqrt u_sqrt_b (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (SQ_IN_W'(rr1_q)),
    .root_o (rt1)
  );

  tlik_sqrt u_sqrt_e (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (SQ_IN_W'(rr2_q)),
    .root_o (rt2)
  );

  // acos(x) = atan2(sqrt(1 - x^2), x), operands scaled by 2^14
  assign yb = XW'({rt1[Q_W-1:0], 14'b0});
  assign xb = XW'(sb_q[P6].cq1) <<< 14;
  assign yc = XW'({rt2[Q_W-1:0], 14'b0});
  assign xc = XW'(sb_q[P6].cq2) <<< 14;
  assign yd = XW'(sb_q[P6].dy) <<< 14;
  assign xd = XW'(sb_q[P6].dx) <<< 14;

  tlik_cordic u_cordic_b (.clk_i(clk_i), .en_i(en), .x_i(xb), .y_i(yb), .z_o(bz));
  tlik_cordic u_cordic_c (.clk_i(clk_i), .en_i(en), .x_i(xc), .y_i(yc), .z_o(cz));
  tlik_cordic u_cordic_d (.clk_i(clk_i), .en_i(en), .x_i(xd), .y_i(yd), .z_o(dz));

  assign base_z  = dz + bz;
  assign outer_z = base_z + HALF_TURN + cz;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sb_q[PZ].zero) begin
        // target on the pivot: straight up, elbow folded back
        base_q  <= to_angle(QUARTER_TURN);
        outer_q <= to_angle(QUARTER_TURN + HALF_TURN);
        reach_q <= 1'b0;
        degen_q <= 1'b1;
      end else begin
        base_q  <= to_angle(base_z);
        outer_q <= to_angle(outer_z);
        reach_q <= sb_q[PZ].reach;
        degen_q <= sb_q[PZ].sat;
      end
    end
  end

  assign out_valid_o    = sb_q[POUT].valid;
  assign base_angle_o   = base_q;
  assign outer_angle_o  = outer_q;
  assign out_of_reach_o = reach_q;
  assign degenerate_o   = degen_q;

endmodule

// ===== rtl/tlik_checker.sv =====
// Port-level checks for the two-link arm solver, bound to the top level.
// Depends on tlik_pkg.
module tlik_checker import tlik_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic [COORD_BITS-1:0] target_x_i,
  input logic [COORD_BITS-1:0] target_y_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [ANGLE_BITS-1:0] base_angle_o,
  input logic [ANGLE_BITS-1:0] outer_angle_o,
  input logic                  out_of_reach_o,
  input logic                  degenerate_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(base_angle_o)
      && $stable(outer_angle_o) && $stable(out_of_reach_o) && $stable(degenerate_o))
    else $error("result beat changed while stalled");

  // a waiting input beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(target_x_i)
      && $stable(target_y_i))
    else $error("input beat changed while waiting");

  // the pipeline only stalls on a waiting result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("in_ready does not follow output stall");

  // a new result only appears on a cycle the pipeline advanced
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("output became valid without pipeline advance");

  // a clamped reach gives cosines of exactly +-1, so no saturation
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_reach_o |-> !degenerate_o)
    else $error("flag state inconsistent");

endmodule

bind two_link_inverse_kinematics tlik_checker u_tlik_checker (.*);

// ===== test/tb_two_link_inverse_kinematics.sv =====
// Testbench for two_link_inverse_kinematics: random and directed target points,
// scoreboard with its own fixed-point arm solver. Depends on tlik_pkg and the RTL.
module tb_two_link_inverse_kinematics;
  import tlik_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ANGLE_BITS-1:0] base_angle;
    logic [ANGLE_BITS-1:0] outer_angle;
    logic                  out_of_reach;
    logic                  degenerate;
  } pose_t;

  class arm_scoreboard;
    logic [COORD_BITS-1:0] pivot_x, pivot_y;
    logic [LEN_BITS-1:0]   len_a, len_b;
    pose_t                 pending[$];
    int                    errors;
    bit [31:0]             arctan[28];

    function new();
      arctan = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
                 32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
                 32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
                 32'h00000014, 32'h0000000A, 32'h00000005};
      pivot_x = 200; pivot_y = 200; len_a = 100; len_b = 100;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_BASE_X:        pivot_x = val[COORD_BITS-1:0];
        CFG_BASE_Y:        pivot_y = val[COORD_BITS-1:0];
        CFG_FIRST_LENGTH:  len_a   = val[LEN_BITS-1:0];
        CFG_SECOND_LENGTH: len_b   = val[LEN_BITS-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // vectoring CORDIC, result in 2^-32 turn
    function bit [31:0] heading(longint y, longint x);
      bit [31:0] z;
      longint t, xs, ys;
      z = 0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; z = QUARTER_TURN;
        end else begin
          x = -y; y = t; z = 32'd0 - QUARTER_TURN;
        end
      end
      for (int i = 0; i < 28; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += arctan[i];
        end else begin
          x -= ys; y += xs; z -= arctan[i];
        end
      end
      return z;
    endfunction

    function longint cosine(longint num, longint unsigned den, inout bit sat);
      longint unsigned mag;
      mag = longint'(num < 0 ? -num : num);
      mag = (mag << 16) / den;
      if (mag > 65536) begin
        mag = 65536;
        sat = 1;
      end
      return num < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    function bit [31:0] arccos(longint cq);
      longint unsigned s;
      s = int_sqrt((64'd1 << 32) - longint'(cq * cq));
      return heading(longint'(s) * 16384, cq * 16384);
    endfunction

    function logic [ANGLE_BITS-1:0] to_binangle(bit [31:0] z);
      bit [31:0] r;
      r = (z + (32'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
      return r[ANGLE_BITS-1:0];
    endfunction

    function void note_target(logic [COORD_BITS-1:0] tx, logic [COORD_BITS-1:0] ty);
      pose_t p;
      longint dx, dy, num;
      longint unsigned a, b, d2, sum, c8;
      bit sat;
      bit [31:0] bz, cz, dz, base;
      dx = longint'(tx) - longint'(pivot_x);
      dy = longint'(ty) - longint'(pivot_y);
      a = (len_a == 0) ? 1 : len_a;
      b = (len_b == 0) ? 1 : len_b;
      d2 = dx * dx + dy * dy;
      sum = a + b;
      sat = 0;
      p.out_of_reach = 0;
      if (d2 == 0) begin
        p.base_angle  = to_binangle(QUARTER_TURN);
        p.outer_angle = to_binangle(QUARTER_TURN + HALF_TURN);
        p.degenerate  = 1;
      end else begin
        if (d2 > sum * sum) begin
          p.out_of_reach = 1;
          c8 = sum << 8;
        end else begin
          c8 = int_sqrt(d2 << 16);
        end
        num = longint'((a * a) << 16) + longint'(c8 * c8) - longint'((b * b) << 16);
        bz = arccos(cosine(num, (2 * a * c8) << 8, sat));
        num = longint'((a * a + b * b) << 16) - longint'(c8 * c8);
        cz = arccos(cosine(num, (2 * a * b) << 16, sat));
        dz = heading(dy * 16384, dx * 16384);
        base = dz + bz;
        p.base_angle  = to_binangle(base);
        p.outer_angle = to_binangle(base + HALF_TURN + cz);
        p.degenerate  = sat;
      end
      pending.push_back(p);
    endfunction

    function void check_pose(pose_t got);
      pose_t want;
      if (pending.size() == 0) begin
        $error("unexpected result beat: base_angle %0d", got.base_angle);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.base_angle !== want.base_angle) begin
        $error("base_angle: expected %0d, actual %0d", want.base_angle, got.base_angle);
        errors++;
      end
      if (got.outer_angle !== want.outer_angle) begin
        $error("outer_angle: expected %0d, actual %0d", want.outer_angle, got.outer_angle);
        errors++;
      end
      if (got.out_of_reach !== want.out_of_reach) begin
        $error("out_of_reach: expected %0d, actual %0d", want.out_of_reach,
               got.out_of_reach);
        errors++;
      end
      if (got.degenerate !== want.degenerate) begin
        $error("degenerate: expected %0d, actual %0d", want.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  localparam int SETTLE = 120;       // longer than the pipeline latency
  localparam int LIMIT  = 600000;

  logic                  clk_i, rst_ni;
  logic                  cfg_we_i;
  logic [1:0]            cfg_idx_i;
  logic [CFG_W-1:0]      cfg_data_i;
  logic                  in_valid_i, in_ready_o;
  logic [COORD_BITS-1:0] target_x_i, target_y_i;
  logic                  out_valid_o, out_ready_i;
  logic [ANGLE_BITS-1:0] base_angle_o, outer_angle_o;
  logic                  out_of_reach_o, degenerate_o;

  arm_scoreboard sb = new();
  bit calm;          // no idling on either side
  int hold_req;      // long receiver stalls asked for by the sender
  int hold_done;     // long receiver stalls carried out
  int cycles;

  two_link_inverse_kinematics dut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("two_link_inverse_kinematics verification failed");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_pose('{base_angle_o, outer_angle_o, out_of_reach_o, degenerate_o});

  // result side: ready with random bursts of stall, and long stalls on request
  initial begin
    out_ready_i <= 0;
    @(posedge rst_ni);
    forever begin
      if (hold_req != hold_done) begin
        out_ready_i <= 0;
        repeat (400) @(posedge clk_i);
        hold_done = hold_req;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic send_target(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
    in_valid_i <= 1;
    target_x_i <= x;
    target_y_i <= y;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_target(x, y);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic set_arm(int bx, int by, int la, int lb);
    write_reg(CFG_BASE_X, CFG_W'(bx));
    write_reg(CFG_BASE_Y, CFG_W'(by));
    write_reg(CFG_FIRST_LENGTH, CFG_W'(la));
    write_reg(CFG_SECOND_LENGTH, CFG_W'(lb));
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  // mix of points near the pivot, exact pivot hits and anywhere on the grid
  task automatic random_targets(int n);
    int x, y;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: begin
          x = sb.pivot_x; y = sb.pivot_y;
        end
        1, 2, 3, 4: begin
          x = int'(sb.pivot_x) + $urandom_range(0, 2 * (sb.len_a + sb.len_b)) -
              (sb.len_a + sb.len_b);
          y = int'(sb.pivot_y) + $urandom_range(0, 2 * (sb.len_a + sb.len_b)) -
              (sb.len_a + sb.len_b);
          x = (x < 0) ? 0 : (x > 1023) ? 1023 : x;
          y = (y < 0) ? 0 : (y > 1023) ? 1023 : y;
        end
        default: begin
          x = $urandom_range(0, 1023); y = $urandom_range(0, 1023);
        end
      endcase
      send_target(COORD_BITS'(x), COORD_BITS'(y));
    end
  endtask

  initial begin
    calm       = 0;
    rst_ni     <= 0;
    cfg_we_i   <= 0;
    cfg_idx_i  <= CFG_BASE_X;
    cfg_data_i <= '0;
    in_valid_i <= 0;
    target_x_i <= '0;
    target_y_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed, reset settings: pivot, axes, corners, edge of reach
    send_target(200, 200);
    send_target(300, 200);
    send_target(200, 300);
    send_target(100, 200);
    send_target(200, 100);
    send_target(0, 0);
    send_target(1023, 1023);
    send_target(0, 1023);
    send_target(1023, 0);
    send_target(341, 341);
    send_target(400, 200);
    send_target(401, 200);
    send_target(201, 200);
    send_target(10'h2AA, 10'h155);
    send_target(10'h155, 10'h2AA);
    random_targets(110);
    drain();

    // zero lengths count as one; pivot in a corner
    set_arm(0, 0, 0, 0);
    send_target(0, 0);
    send_target(1, 0);
    send_target(2, 0);
    send_target(1, 1);
    send_target(1023, 1023);
    random_targets(60);
    hold_req++;        // result side stalls long enough to back up the pipeline
    random_targets(120);
    drain();

    // longest arms, pivot at the far corner; bit 9 of the data is dropped for lengths
    set_arm(1023, 1023, 511, 10'h3FF);
    send_target(0, 0);
    send_target(1023, 1023);
    random_targets(120);
    drain();

    // very unequal arms: inner zone is out of reach
    set_arm(512, 300, 500, 10);
    send_target(512, 300);
    send_target(520, 300);
    send_target(512, 790);
    send_target(1023, 300);
    random_targets(120);
    drain();

    set_arm(0, 1023, 1, 511);
    random_targets(180);
    drain();

    set_arm($urandom_range(0, 1023), $urandom_range(0, 1023),
            $urandom_range(0, 511), $urandom_range(0, 511));
    random_targets(80);
    calm = 1;
    random_targets(80);
    drain();

    if (sb.errors == 0)
      $display("two_link_inverse_kinematics verification clean");
    else
      $display("two_link_inverse_kinematics verification failed");
    $finish;
  end

endmodule
